FILE: design/modular_exponentiation_core_defines.svh
// Assertion macros for the modular exponentiation core.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ME_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ME_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ME_ASSERT_IMPL(label, clk, rst_n, prop)
`define ME_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: design/modexp_pkg.sv
// Shared types and constants for the modular exponentiation core.
// No dependencies.
package modexp_pkg;
    localparam int MOD_WIDTH_DEF = 31;
    localparam int IN_WIDTH      = 32;
    localparam longint unsigned MOD_RESET = 64'd2147483647;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MULT,
        ST_SQUARE,
        ST_DONE
    } t_state;
endpackage

FILE: design/modexp_in_if.sv
// Input channel: base and exponent with a valid/ready handshake.
// Depends on modexp_pkg.
interface modexp_in_if;
    import modexp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [IN_WIDTH-1:0]   base_value;
    logic [IN_WIDTH-1:0]   exponent;
    modport source (output valid, base_value, exponent, input ready);
    modport sink   (input valid, base_value, exponent, output ready);
endinterface

FILE: design/modexp_out_if.sv
// Output channel: power result with a valid/ready handshake.
// Parameterized by the modulus width.
interface modexp_out_if #(parameter int MOD_WIDTH = 31);
    logic                 valid;
    logic                 ready;
    logic [MOD_WIDTH-1:0] power_result;
    modport source (output valid, power_result, input ready);
    modport sink   (input valid, power_result, output ready);
endinterface

FILE: design/modexp_cell.sv
// One bit cell of the serial modular multiplier: adds its partial residue
// bit and the gated addend bit, passing carries on. No dependencies.
module modexp_cell (
    input  logic i_r,
    input  logic i_a,
    input  logic i_add,
    input  logic i_cin,
    output logic o_sum,
    output logic o_cout
);
    logic w_b;
    assign w_b    = i_add & i_a;
    assign o_sum  = i_r ^ w_b ^ i_cin;
    assign o_cout = (i_r & w_b) | (i_r & i_cin) | (w_b & i_cin);
endmodule

FILE: design/modexp_mulrow.sv
// Row of bit cells forming one shift-and-add step with reduction:
// r = 2r mod m, then r = r + a mod m when the multiplier bit is set.
// Depends on modexp_cell.
module modexp_mulrow #(
    parameter int MOD_WIDTH = 31
) (
    input  logic [MOD_WIDTH-1:0] i_r,
    input  logic [MOD_WIDTH-1:0] i_a,
    input  logic [MOD_WIDTH-1:0] i_m,
    input  logic                 i_bit,
    output logic [MOD_WIDTH-1:0] o_r
);
    logic [MOD_WIDTH:0]   w_dbl;
    logic [MOD_WIDTH:0]   w_dred;
    logic [MOD_WIDTH-1:0] w_d;
    logic [MOD_WIDTH:0]   w_carry;
    logic [MOD_WIDTH:0]   w_sum;
    logic [MOD_WIDTH:0]   w_sred;

    assign w_dbl  = {i_r, 1'b0};
    assign w_dred = w_dbl - {1'b0, i_m};
    assign w_d    = (w_dbl >= {1'b0, i_m}) ? w_dred[MOD_WIDTH-1:0] : w_dbl[MOD_WIDTH-1:0];

    assign w_carry[0] = 1'b0;
    for (genvar g = 0; g < MOD_WIDTH; g++) begin : g_cell
        modexp_cell u_cell (
            .i_r   (w_d[g]),
            .i_a   (i_a[g]),
            .i_add (i_bit),
            .i_cin (w_carry[g]),
            .o_sum (w_sum[g]),
            .o_cout(w_carry[g+1])
        );
    end
    assign w_sum[MOD_WIDTH] = w_carry[MOD_WIDTH];
    assign w_sred = w_sum - {1'b0, i_m};
    assign o_r    = (w_sum >= {1'b0, i_m}) ? w_sred[MOD_WIDTH-1:0] : w_sum[MOD_WIDTH-1:0];
endmodule

FILE: design/modular_exponentiation_core.sv
// Modular exponentiation core: right-to-left square-and-multiply.
// Channels: in (base_value, exponent) and out (power_result), valid/ready.
// Config: i_cfg_we/i_cfg_wdata write the modulus (reset 2^31-1); modulus 0
// acts as 1. Write only while idle.
// One item at a time. The base is first reduced by a restoring pass over its
// 32 bits, one dividend bit per cycle. The multiply for the lowest set
// exponent bit just takes the reduced base, since the running result is
// still one. Each later exponent bit takes a square and, when set, a
// multiply, each over MOD_WIDTH multiplier bits through one shared
// shift-and-add row; the square state ends the item when no set bits are
// left. Exponent zero goes straight from the reduction to the result.
// The result sits in an output register until taken; a stalled receiver
// holds the block in its done state and no new item is accepted.
// Synchronous active-low reset returns to idle and restores the modulus.
// Depends on modexp_pkg, modexp_in_if, modexp_out_if, modexp_mulrow.
`include "modular_exponentiation_core_defines.svh"
module modular_exponentiation_core #(
    parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [MOD_WIDTH-1:0] i_cfg_wdata,
    modexp_in_if.sink            in_ch,
    modexp_out_if.source         out_ch
);
    import modexp_pkg::*;

    localparam int CW = $clog2(IN_WIDTH + MOD_WIDTH + 1);
    localparam int BW = $clog2(MOD_WIDTH);
    localparam logic [MOD_WIDTH-1:0] MOD_RST = MOD_WIDTH'(MOD_RESET);
    localparam logic [MOD_WIDTH-1:0] ONE = MOD_WIDTH'(1);

    t_state r_state, n_state;
    logic [MOD_WIDTH-1:0] r_mod;
    logic [MOD_WIDTH-1:0] r_base, n_base;
    logic [MOD_WIDTH-1:0] r_res, n_res;
    logic [MOD_WIDTH-1:0] r_acc, n_acc;
    logic [IN_WIDTH-1:0]  r_exp, n_exp;
    logic [IN_WIDTH-1:0]  r_div, n_div;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_first, n_first;
    logic [MOD_WIDTH-1:0] w_m;
    logic [MOD_WIDTH-1:0] w_row;
    logic [MOD_WIDTH-1:0] w_mula;
    logic [MOD_WIDTH-1:0] w_mulb;
    logic [BW-1:0]        w_bidx;
    logic                 w_bit;
    logic [MOD_WIDTH:0]   w_rem;
    logic [MOD_WIDTH:0]   w_remsub;

    assign w_m = (r_mod == '0) ? ONE : r_mod;

    // shared multiplier row; in ST_MULT a = base, b = res; in ST_SQUARE both base
    assign w_mula = r_base;
    assign w_mulb = (r_state == ST_MULT) ? r_res : r_base;
    assign w_bidx = r_cnt[BW-1:0] - 1'b1;
    assign w_bit  = w_mulb[w_bidx];

    modexp_mulrow #(.MOD_WIDTH(MOD_WIDTH)) u_row (
        .i_r  (r_acc),
        .i_a  (w_mula),
        .i_m  (w_m),
        .i_bit(w_bit),
        .o_r  (w_row)
    );

    // restoring reduction of the base, one dividend bit per cycle
    assign w_rem    = {r_base, r_div[IN_WIDTH-1]};
    assign w_remsub = w_rem - {1'b0, w_m};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_RST;
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_res   <= n_res;
        r_acc   <= n_acc;
        r_exp   <= n_exp;
        r_div   <= n_div;
        r_cnt   <= n_cnt;
        r_first <= n_first;
    end

    always_comb begin
        n_state = r_state;
        n_base  = r_base;
        n_res   = r_res;
        n_acc   = r_acc;
        n_exp   = r_exp;
        n_div   = r_div;
        n_cnt   = r_cnt;
        n_first = r_first;
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ch.ready = 1'b1;
                if (in_ch.valid) begin
                    n_base  = '0;
                    n_div   = in_ch.base_value;
                    n_exp   = in_ch.exponent;
                    n_res   = ONE;
                    n_first = 1'b1;
                    n_cnt   = CW'(IN_WIDTH);
                    n_state = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                n_base = (w_rem >= {1'b0, w_m}) ? w_remsub[MOD_WIDTH-1:0]
                                                : w_rem[MOD_WIDTH-1:0];
                n_div  = r_div << 1;
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_acc = '0;
                    n_cnt = CW'(MOD_WIDTH);
                    if (r_exp == '0) begin
                        n_state = ST_DONE;
                    end else if (r_exp[0]) begin
                        n_state = ST_MULT;
                    end else begin
                        n_state = ST_SQUARE;
                    end
                end
            end
            ST_MULT: begin
                if (r_first) begin
                    // first multiply is by one: take the reduced base
                    n_res   = r_base;
                    n_first = 1'b0;
                    n_acc   = '0;
                    n_cnt   = CW'(MOD_WIDTH);
                    n_state = ST_SQUARE;
                end else begin
                    n_acc = w_row;
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        n_res   = w_row;
                        n_acc   = '0;
                        n_cnt   = CW'(MOD_WIDTH);
                        n_state = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE: begin
                if (r_exp[IN_WIDTH-1:1] == '0) begin
                    // no set bits left: squaring no longer matters
                    n_state = ST_DONE;
                end else begin
                    n_acc = w_row;
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        n_base  = w_row;
                        n_acc   = '0;
                        n_cnt   = CW'(MOD_WIDTH);
                        n_exp   = r_exp >> 1;
                        n_state = r_exp[1] ? ST_MULT : ST_SQUARE;
                    end
                end
            end
            ST_DONE: begin
                out_ch.valid = 1'b1;
                if (out_ch.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign out_ch.power_result = r_res;

    `ME_ASSERT_IMPL(a_one_side, i_clk, i_rst_n, !(in_ch.ready && out_ch.valid))
    `ME_ASSERT_IMPL(a_done_hold, i_clk, i_rst_n,
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(r_res)))
    `ME_ASSERT_IMPL(a_res_range, i_clk, i_rst_n,
        (r_state == ST_SQUARE && !r_first) |-> (r_res < w_m))
    `ME_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n,
        (r_state == ST_MULT || r_state == ST_SQUARE) |-> (r_cnt <= CW'(MOD_WIDTH)))
endmodule

FILE: dv/modexp_checker.sv
// Watches the input and result channels of the modular exponentiation core,
// predicts each result by square-and-multiply and compares. Depends on
// modexp_pkg, modexp_in_if and modexp_out_if.
module modexp_checker #(
    parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [MOD_WIDTH-1:0] i_cfg_wdata,
    modexp_in_if                 in_ch,
    modexp_out_if                out_ch,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import modexp_pkg::*;

    logic [MOD_WIDTH-1:0] modulus_q;
    logic [MOD_WIDTH-1:0] power_queue[$];

    // shift-and-add product, reduced after each step, multiplier MSB first
    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [63:0] acc;
        acc = 0;
        for (int i = MOD_WIDTH - 1; i >= 0; i--) begin
            acc = acc << 1;
            if (acc >= m) acc -= m;
            if (b[i]) begin
                acc += a;
                if (acc >= m) acc -= m;
            end
        end
        return acc;
    endfunction

    function automatic logic [MOD_WIDTH-1:0] predict_power(logic [IN_WIDTH-1:0] base_in,
                                                           logic [IN_WIDTH-1:0] exp_in,
                                                           logic [MOD_WIDTH-1:0] mod_in);
        logic [63:0] m;
        logic [63:0] b;
        logic [63:0] r;
        logic [IN_WIDTH-1:0] e;
        bit          first;
        m = (mod_in == 0) ? 64'd1 : 64'(mod_in);
        b = 64'(base_in) % m;
        e = exp_in;
        r = 1;
        first = 1;
        while (e != 0) begin
            if (e[0]) begin
                r = first ? b : mulmod(r, b, m);
                first = 0;
            end
            e = e >> 1;
            b = mulmod(b, b, m);
        end
        return r[MOD_WIDTH-1:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH %s", $realtime, what);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = power_queue.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            modulus_q <= MOD_WIDTH'(MOD_RESET);
        end else begin
            if (i_cfg_we) modulus_q <= i_cfg_wdata;
            if (in_ch.valid && in_ch.ready)
                power_queue.push_back(predict_power(in_ch.base_value, in_ch.exponent,
                                                    modulus_q));
            if (out_ch.valid && out_ch.ready) begin
                if (power_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %0d", out_ch.power_result));
                end else begin
                    if (out_ch.power_result !== power_queue[0])
                        report_mismatch($sformatf("power_result %0d, want %0d",
                                                  out_ch.power_result, power_queue[0]));
                    void'(power_queue.pop_front());
                end
            end
        end
    end
endmodule

FILE: dv/tb_modular_exponentiation_core.sv
// Top of the modular exponentiation core testbench: clock, reset, modulus
// writes, stimulus and result-side stalls; the verdict uses modexp_checker.
module tb_modular_exponentiation_core;
    timeunit 1ns;
    timeprecision 1ps;
    import modexp_pkg::*;

    localparam int MW = MOD_WIDTH_DEF;
    localparam int MAX_CYCLES = 2_500_000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [MW-1:0] i_cfg_wdata;
    int            fail_count;
    int            pending;
    int            cycle_count;
    bit            idle_free;
    bit            hold_off;
    bit            stim_done;

    modexp_in_if           in_ch ();
    modexp_out_if #(MW)    out_ch ();

    modular_exponentiation_core #(.MOD_WIDTH(MW)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    modexp_checker #(.MOD_WIDTH(MW)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > MAX_CYCLES) begin
                $display("modular_exponentiation_core verification failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off
    initial begin
        out_ch.ready = 0;
        hold_off = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off)
                out_ch.ready <= 0;
            else
                out_ch.ready <= idle_free || ($urandom_range(99) >= 20);
        end
    end

    // leave valid high on return; the next call or the caller drops it
    task automatic send_word(logic [31:0] b, logic [31:0] e);
        while (!idle_free && $urandom_range(99) < 20) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1;
        in_ch.base_value <= b;
        in_ch.exponent   <= e;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic write_modulus(logic [MW-1:0] m);
        in_ch.valid <= 0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic logic [31:0] pick_field();
        case ($urandom_range(5))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [MW-1:0] mod_set[6];
        in_ch.valid = 0;
        in_ch.base_value = 0;
        in_ch.exponent = 0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        idle_free = 0;
        stim_done = 0;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset modulus, then corner moduli
        send_word(32'd5, 32'd0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'd0, 32'd7);
        send_word(32'h7FFF_FFFF, 32'd1);
        send_word(32'd2, 32'd30);
        send_word(32'h8000_0000, 32'h8000_0001);
        send_word(32'd3, 32'h5555_5555);
        send_word(32'hAAAA_AAAA, 32'hAAAA_AAAA);
        write_modulus(MW'(1));
        send_word(32'd9, 32'd0);
        send_word(32'd9, 32'd3);
        write_modulus(MW'(0));
        send_word(32'hFFFF_FFFF, 32'd0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_modulus(MW'(2));
        send_word(32'd3, 32'd5);
        send_word(32'd4, 32'd5);
        write_modulus(MW'(13));
        send_word(32'd13, 32'd4);
        send_word(32'd14, 32'd12);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFE);

        mod_set = '{31'h7FFF_FFFF, 31'd1000003, 31'd97, 31'h4000_0000, 31'd7, 31'd65521};
        for (int ph = 0; ph < 6; ph++) begin
            write_modulus(ph == 5 ? MW'($urandom) : mod_set[ph]);
            idle_free = (ph == 2);
            for (int n = 0; n < 44; n++) begin
                // long receiver stall while the sender keeps offering words
                if (ph == 1 && n == 5) begin
                    fork
                        begin
                            hold_off = 1;
                            repeat (6000) @(posedge i_clk);
                            hold_off = 0;
                        end
                    join_none
                end
                send_word(pick_field(), pick_field());
            end
        end
        in_ch.valid <= 0;
        idle_free = 0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("modular_exponentiation_core verification clean");
        else
            $display("modular_exponentiation_core verification failed");
        $finish;
    end
endmodule
